>>> hdl/clrc_pkg.sv
package clrc_pkg;

    localparam int LATTICE_SIZE = 8;
    localparam int HALF_SIZE    = LATTICE_SIZE / 2;
    localparam int IDX_W        = $clog2(LATTICE_SIZE);
    localparam int ITER_W       = (HALF_SIZE > 1) ? $clog2(HALF_SIZE) : 1;

    localparam logic [63:0] C_PERT_GAIN  = $realtobits(0.071428571);
    localparam logic [63:0] C_PERT_SCALE = $realtobits(0.666666667);
    localparam logic [63:0] C_TENT       = $realtobits(1.99999);
    localparam logic [63:0] C_SELF_W     = $realtobits(1.0 - 0.05);
    localparam logic [63:0] C_CROSS_W    = $realtobits(0.05 / 2.0);
    localparam logic [63:0] C_ONE        = $realtobits(1.0);
    localparam logic [63:0] C_HALF       = $realtobits(0.5);

    typedef enum logic {
        FP_ADD,
        FP_MUL
    } fp_op_t;

    typedef struct packed {
        logic        start;
        fp_op_t      op;
        logic [63:0] a;
        logic [63:0] b;
    } fp_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fp_rsp_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_MNORM,
        FS_ALIGN,
        FS_SUM,
        FS_NORM,
        FS_ROUND
    } fpu_st_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERT_MUL,
        ST_PERT_ADD,
        ST_PERT_SCALE,
        ST_TENT_SUB,
        ST_TENT_MUL,
        ST_MIX_SELF,
        ST_MIX_LEFT,
        ST_MIX_SUM,
        ST_MIX_CROSS,
        ST_MIX_ADD,
        ST_EMIT_LOAD,
        ST_EMIT_OUT
    } st_t;

    function automatic logic [63:0] seed_bits(input logic [2:0] idx);
        logic [63:0] v;
        unique case (idx)
            3'd0: v = $realtobits(0.141592);
            3'd1: v = $realtobits(0.653589);
            3'd2: v = $realtobits(0.793238);
            3'd3: v = $realtobits(0.462643);
            3'd4: v = $realtobits(0.383279);
            3'd5: v = $realtobits(0.502884);
            3'd6: v = $realtobits(0.197169);
            default: v = $realtobits(0.399375);
        endcase
        return v;
    endfunction

    function automatic logic [63:0] small_to_double(input logic [2:0] s);
        logic [63:0] v;
        unique case (s)
            3'd0: v = 64'd0;
            3'd1: v = $realtobits(1.0);
            3'd2: v = $realtobits(2.0);
            3'd3: v = $realtobits(3.0);
            3'd4: v = $realtobits(4.0);
            3'd5: v = $realtobits(5.0);
            3'd6: v = $realtobits(6.0);
            default: v = $realtobits(7.0);
        endcase
        return v;
    endfunction

endpackage

>>> hdl/chaotic_lattice_random_conditioner.sv
// Conditions noise bytes into random 64-bit words with a lattice of eight
// double-precision tent-map cells. Only bits 2..0 of each s_tdata byte count.
// Every sample perturbs the next cell; the eighth sample of a block then runs
// four coupled lattice passes (up to six double ops per cell and pass, five
// when the cell is below one half) before the four output beats, the last
// marked by m_tlast. All arithmetic runs on the single shared double-precision
// add/multiply unit, which handles one operation at a time. s_tready is high
// only while the block waits for a sample; a finished beat is held in an
// output register and does not stop the next sample.
module chaotic_lattice_random_conditioner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] word
    output logic        m_tlast
);

    localparam int L  = clrc_pkg::LATTICE_SIZE;
    localparam int IW = clrc_pkg::IDX_W;
    localparam int TW = clrc_pkg::ITER_W;

    clrc_pkg::st_t state_reg, state_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] k_reg, k_next;
    logic [TW-1:0] iter_reg, iter_next;
    logic          issued_reg, issued_next;
    logic [2:0]    sample_reg, sample_next;
    logic [63:0]   tmp_reg, tmp_next;
    logic [63:0]   self_reg, self_next;
    logic [63:0]   lattice_reg [L];
    logic [63:0]   fv_reg [L];
    logic          m_tvalid_reg, m_tvalid_next;
    logic [63:0]   m_tdata_reg, m_tdata_next;
    logic          m_tlast_reg, m_tlast_next;

    logic          lat_we, fv_we;
    logic [63:0]   lat_wdata, fv_wdata;
    logic [IW-1:0] lat_addr, fv_addr, k_left, k_right;
    logic [63:0]   lat_rd, fv_rd;
    logic          lt_half, fp_fire;

    clrc_pkg::fp_req_t req;
    clrc_pkg::fp_rsp_t rsp;

    clrc_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    always_comb begin
        k_left  = (k_reg == '0) ? IW'(L - 1) : k_reg - IW'(1);
        k_right = (k_reg == IW'(L - 1)) ? '0 : k_reg + IW'(1);
        lat_rd  = lattice_reg[lat_addr];
        fv_rd   = fv_reg[fv_addr];
        lt_half = lat_rd[63] | (lat_rd[62:0] < clrc_pkg::C_HALF[62:0]);
        fp_fire = issued_reg & rsp.done;
    end

    // outputs: read addresses and unit requests
    always_comb begin
        s_tready  = (state_reg == clrc_pkg::ST_IDLE);
        lat_addr  = k_reg;
        fv_addr   = k_reg;
        req.start = 1'b0;
        req.op    = clrc_pkg::FP_MUL;
        req.a     = tmp_reg;
        req.b     = tmp_reg;
        unique case (state_reg)
            clrc_pkg::ST_PERT_MUL: begin
                req.start = !issued_reg;
                req.a     = clrc_pkg::C_PERT_GAIN;
                req.b     = clrc_pkg::small_to_double(sample_reg);
            end
            clrc_pkg::ST_PERT_ADD: begin
                lat_addr  = pos_reg;
                req.start = !issued_reg;
                req.op    = clrc_pkg::FP_ADD;
                req.b     = lat_rd;
            end
            clrc_pkg::ST_PERT_SCALE: begin
                req.start = !issued_reg;
                req.a     = clrc_pkg::C_PERT_SCALE;
            end
            clrc_pkg::ST_TENT_SUB: begin
                req.start = !issued_reg && !lt_half;
                req.op    = clrc_pkg::FP_ADD;
                req.a     = clrc_pkg::C_ONE;
                req.b     = {~lat_rd[63], lat_rd[62:0]};
            end
            clrc_pkg::ST_TENT_MUL: begin
                req.start = !issued_reg;
                req.a     = clrc_pkg::C_TENT;
            end
            clrc_pkg::ST_MIX_SELF: begin
                req.start = !issued_reg;
                req.a     = clrc_pkg::C_SELF_W;
                req.b     = fv_rd;
            end
            clrc_pkg::ST_MIX_LEFT: fv_addr = k_left;
            clrc_pkg::ST_MIX_SUM: begin
                fv_addr   = k_right;
                req.start = !issued_reg;
                req.op    = clrc_pkg::FP_ADD;
                req.b     = fv_rd;
            end
            clrc_pkg::ST_MIX_CROSS: begin
                req.start = !issued_reg;
                req.a     = clrc_pkg::C_CROSS_W;
            end
            clrc_pkg::ST_MIX_ADD: begin
                req.start = !issued_reg;
                req.op    = clrc_pkg::FP_ADD;
                req.a     = self_reg;
            end
            clrc_pkg::ST_EMIT_LOAD: lat_addr = k_reg + IW'(clrc_pkg::HALF_SIZE);
            default: ;
        endcase
    end

    // next state and datapath
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        iter_next     = iter_reg;
        sample_next   = sample_reg;
        tmp_next      = tmp_reg;
        self_next     = self_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        lat_we        = 1'b0;
        lat_wdata     = rsp.result;
        fv_we         = 1'b0;
        fv_wdata      = rsp.result;
        issued_next   = req.start ? 1'b1 : (fp_fire ? 1'b0 : issued_reg);
        unique case (state_reg)
            clrc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[2:0];
                    state_next  = clrc_pkg::ST_PERT_MUL;
                end
            end
            clrc_pkg::ST_PERT_MUL: begin
                if (fp_fire) begin
                    tmp_next   = rsp.result;
                    state_next = clrc_pkg::ST_PERT_ADD;
                end
            end
            clrc_pkg::ST_PERT_ADD: begin
                if (fp_fire) begin
                    tmp_next   = rsp.result;
                    state_next = clrc_pkg::ST_PERT_SCALE;
                end
            end
            clrc_pkg::ST_PERT_SCALE: begin
                if (fp_fire) begin
                    lat_we = 1'b1;
                    if (pos_reg == IW'(L - 1)) begin
                        pos_next   = '0;
                        k_next     = '0;
                        iter_next  = '0;
                        state_next = clrc_pkg::ST_TENT_SUB;
                    end else begin
                        pos_next   = pos_reg + IW'(1);
                        state_next = clrc_pkg::ST_IDLE;
                    end
                end
            end
            clrc_pkg::ST_TENT_SUB: begin
                if (lt_half && !issued_reg) begin
                    tmp_next   = lat_rd;
                    state_next = clrc_pkg::ST_TENT_MUL;
                end else if (fp_fire) begin
                    tmp_next   = rsp.result;
                    state_next = clrc_pkg::ST_TENT_MUL;
                end
            end
            clrc_pkg::ST_TENT_MUL: begin
                if (fp_fire) begin
                    fv_we = 1'b1;
                    if (k_reg == IW'(L - 1)) begin
                        k_next     = '0;
                        state_next = clrc_pkg::ST_MIX_SELF;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = clrc_pkg::ST_TENT_SUB;
                    end
                end
            end
            clrc_pkg::ST_MIX_SELF: begin
                if (fp_fire) begin
                    self_next  = rsp.result;
                    state_next = clrc_pkg::ST_MIX_LEFT;
                end
            end
            clrc_pkg::ST_MIX_LEFT: begin
                tmp_next   = fv_rd;
                state_next = clrc_pkg::ST_MIX_SUM;
            end
            clrc_pkg::ST_MIX_SUM: begin
                if (fp_fire) begin
                    tmp_next   = rsp.result;
                    state_next = clrc_pkg::ST_MIX_CROSS;
                end
            end
            clrc_pkg::ST_MIX_CROSS: begin
                if (fp_fire) begin
                    tmp_next   = rsp.result;
                    state_next = clrc_pkg::ST_MIX_ADD;
                end
            end
            clrc_pkg::ST_MIX_ADD: begin
                if (fp_fire) begin
                    lat_we = 1'b1;
                    if (k_reg == IW'(L - 1)) begin
                        k_next = '0;
                        if (iter_reg == TW'(clrc_pkg::HALF_SIZE - 1)) begin
                            iter_next  = '0;
                            state_next = clrc_pkg::ST_EMIT_LOAD;
                        end else begin
                            iter_next  = iter_reg + TW'(1);
                            state_next = clrc_pkg::ST_TENT_SUB;
                        end
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = clrc_pkg::ST_MIX_SELF;
                    end
                end
            end
            clrc_pkg::ST_EMIT_LOAD: begin
                tmp_next   = lat_rd;
                state_next = clrc_pkg::ST_EMIT_OUT;
            end
            clrc_pkg::ST_EMIT_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = lat_rd ^ {tmp_reg[31:0], tmp_reg[63:32]};
                    m_tlast_next  = (k_reg == IW'(clrc_pkg::HALF_SIZE - 1));
                    if (k_reg == IW'(clrc_pkg::HALF_SIZE - 1)) begin
                        k_next     = '0;
                        state_next = clrc_pkg::ST_IDLE;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = clrc_pkg::ST_EMIT_LOAD;
                    end
                end
            end
            default: state_next = clrc_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clrc_pkg::ST_IDLE;
            pos_reg      <= '0;
            k_reg        <= '0;
            iter_reg     <= '0;
            issued_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < L; i++) begin
                lattice_reg[i] <= clrc_pkg::seed_bits(3'(i % 8));
            end
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            iter_reg     <= iter_next;
            issued_reg   <= issued_next;
            m_tvalid_reg <= m_tvalid_next;
            if (lat_we) begin
                lattice_reg[(state_reg == clrc_pkg::ST_PERT_SCALE) ? pos_reg : k_reg]
                    <= lat_wdata;
            end
        end
        if (fv_we) begin
            fv_reg[k_reg] <= fv_wdata;
        end
        sample_reg  <= sample_next;
        tmp_reg     <= tmp_next;
        self_reg    <= self_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == clrc_pkg::ST_PERT_MUL)
        else $error("accepted sample did not start the perturb step");

    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> issued_reg)
        else $error("arithmetic result without a pending request");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == clrc_pkg::ST_IDLE |-> !issued_reg)
        else $error("request pending while waiting for a sample");

    a_pos_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == clrc_pkg::ST_TENT_SUB |-> pos_reg == '0)
        else $error("lattice pass started before the block wrapped");

endmodule

>>> hdl/clrc_fpu.sv
module clrc_fpu (
    input  logic              aclk,
    input  logic              aresetn,
    input  clrc_pkg::fp_req_t req,
    output clrc_pkg::fp_rsp_t rsp
);

    clrc_pkg::fpu_st_t state_reg, state_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [105:0] acc_reg, acc_next;
    logic [53:0]  pp_reg, pp_next;
    logic [6:0]   sh_reg, sh_next;
    logic         ppv_reg, ppv_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [12:0]  exp_reg, exp_next;
    logic         sgn_reg, sgn_next;
    logic         sub_reg, sub_next;
    logic [63:0]  res_reg, res_next;
    logic         done_reg, done_next;

    // multiply halves
    logic [52:0] mul_ma, mul_mb;
    logic [26:0] a_half, b_half;

    // add alignment
    logic        a_ge_b;
    logic [63:0] big, small_op;
    logic [52:0] m_big, m_small;
    logic [10:0] e_big, e_small, e_diff;
    logic [55:0] small_full, small_sh, small_ext;
    logic        small_st;
    logic [56:0] sum57;

    // rounding
    logic        rnd_up;
    logic [53:0] m54;
    logic [12:0] exp_rnd;

    always_comb begin
        mul_ma = {1'b1, a_reg[51:0]};
        mul_mb = {1'b1, b_reg[51:0]};
        a_half = cnt_reg[0] ? {1'b0, mul_ma[52:27]} : mul_ma[26:0];
        b_half = cnt_reg[1] ? {1'b0, mul_mb[52:27]} : mul_mb[26:0];

        a_ge_b   = (a_reg[62:0] >= b_reg[62:0]);
        big      = a_ge_b ? a_reg : b_reg;
        small_op = a_ge_b ? b_reg : a_reg;
        e_big    = big[62:52];
        e_small  = small_op[62:52];
        m_big    = {|e_big, big[51:0]};
        m_small  = {|e_small, small_op[51:0]};
        e_diff   = e_big - e_small;
        small_full = {m_small, 3'b000};
        if (e_diff >= 11'd56) begin
            small_sh = 56'd0;
            small_st = |m_small;
        end else begin
            small_sh = small_full >> e_diff[5:0];
            small_st = |(small_full & ((56'd1 << e_diff[5:0]) - 56'd1));
        end
        small_ext = {small_sh[55:1], small_sh[0] | small_st};

        sum57 = sub_reg ? ({1'b0, a_reg[55:0]} - {1'b0, b_reg[55:0]})
                        : ({1'b0, a_reg[55:0]} + {1'b0, b_reg[55:0]});

        rnd_up  = acc_reg[2] & (acc_reg[1] | acc_reg[0] | acc_reg[3]);
        m54     = {1'b0, acc_reg[55:3]} + {53'd0, rnd_up};
        exp_rnd = exp_reg + {12'd0, m54[53]};
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        ppv_next   = ppv_reg;
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        sgn_next   = sgn_reg;
        sub_next   = sub_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            clrc_pkg::FS_IDLE: begin
                if (req.start) begin
                    a_next = req.a;
                    b_next = req.b;
                    if (req.op == clrc_pkg::FP_MUL) begin
                        sgn_next = req.a[63] ^ req.b[63];
                        exp_next = {2'b00, req.a[62:52]} + {2'b00, req.b[62:52]} - 13'd1023;
                        if (req.a[62:52] == 11'd0 || req.b[62:52] == 11'd0) begin
                            res_next  = {req.a[63] ^ req.b[63], 63'd0};
                            done_next = 1'b1;
                        end else begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            ppv_next   = 1'b0;
                            state_next = clrc_pkg::FS_MUL;
                        end
                    end else begin
                        state_next = clrc_pkg::FS_ALIGN;
                    end
                end
            end
            clrc_pkg::FS_MUL: begin
                // accumulate the previous partial product while forming the next
                if (ppv_reg) begin
                    acc_next = acc_reg + ({52'd0, pp_reg} << sh_reg);
                end
                if (cnt_reg != 3'd4) begin
                    pp_next  = a_half * b_half;
                    sh_next  = (cnt_reg[0] ? 7'd27 : 7'd0) + (cnt_reg[1] ? 7'd27 : 7'd0);
                    ppv_next = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end else begin
                    state_next = clrc_pkg::FS_MNORM;
                end
            end
            clrc_pkg::FS_MNORM: begin
                if (acc_reg[105]) begin
                    acc_next = {50'd0, acc_reg[105:51], |acc_reg[50:0]};
                    exp_next = exp_reg + 13'd1;
                end else begin
                    acc_next = {50'd0, acc_reg[104:50], |acc_reg[49:0]};
                end
                state_next = clrc_pkg::FS_ROUND;
            end
            clrc_pkg::FS_ALIGN: begin
                a_next     = {8'd0, m_big, 3'b000};
                b_next     = {8'd0, small_ext};
                sgn_next   = big[63];
                exp_next   = {2'b00, e_big};
                sub_next   = big[63] ^ small_op[63];
                state_next = clrc_pkg::FS_SUM;
            end
            clrc_pkg::FS_SUM: begin
                acc_next   = {49'd0, sum57};
                state_next = clrc_pkg::FS_NORM;
            end
            clrc_pkg::FS_NORM: begin
                priority if (acc_reg[56]) begin
                    acc_next   = {50'd0, acc_reg[56:2], acc_reg[1] | acc_reg[0]};
                    exp_next   = exp_reg + 13'd1;
                    state_next = clrc_pkg::FS_ROUND;
                end else if (acc_reg[55:0] == 56'd0) begin
                    res_next   = 64'd0;
                    done_next  = 1'b1;
                    state_next = clrc_pkg::FS_IDLE;
                end else if (acc_reg[55]) begin
                    state_next = clrc_pkg::FS_ROUND;
                end else if (acc_reg[55:48] == 8'd0) begin
                    acc_next = {50'd0, acc_reg[47:0], 8'd0};
                    exp_next = exp_reg - 13'd8;
                end else begin
                    acc_next = {50'd0, acc_reg[54:0], 1'b0};
                    exp_next = exp_reg - 13'd1;
                end
            end
            clrc_pkg::FS_ROUND: begin
                res_next   = {sgn_reg, exp_rnd[10:0], m54[53] ? 52'd0 : m54[51:0]};
                done_next  = 1'b1;
                state_next = clrc_pkg::FS_IDLE;
            end
            default: state_next = clrc_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        rsp.done   = done_reg;
        rsp.result = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clrc_pkg::FS_IDLE;
            done_reg  <= 1'b0;
            ppv_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ppv_reg   <= ppv_next;
            cnt_reg   <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        exp_reg <= exp_next;
        sgn_reg <= sgn_next;
        sub_reg <= sub_next;
        res_reg <= res_next;
    end

endmodule
